// ===== design/lsps_pkg.sv =====
// Package for the line-sensor PID steering unit: widths, codes and shared types.
package lsps_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int IN_W        = 12;
   localparam int SUM_W       = SAMPLE_BITS + 2;
   localparam int RT_STEPS    = (SUM_W + 33) / 2;
   localparam int RX_W        = 2 * RT_STEPS;
   localparam int RT_W        = RT_STEPS;
   localparam int MAG_W       = RT_W + 14;
   localparam int DEN_W       = SUM_W + 1;
   localparam int DIV_STEPS   = MAG_W;
   localparam int CNT_W       = $clog2(DIV_STEPS + 1);
   localparam int GAIN_W      = 24;
   localparam int OFS_W       = 31;
   localparam int BASE_W      = 15;
   localparam int ERR_W       = 32;
   localparam int DIFF_W      = 33;
   localparam int ISUM_W      = 40;
   localparam int ISUM_LO_W   = 20;
   localparam int MOP_W       = 34;
   localparam int PROD_W      = GAIN_W + 1 + MOP_W;
   localparam int IACC_W      = 65;
   localparam int TERM_W      = 52;
   localparam int DUTY_W      = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 31;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 3'd0,
      CSR_INTEG_GAIN = 3'd1,
      CSR_DERIV_GAIN = 3'd2,
      CSR_TARGET_OFS = 3'd3,
      CSR_BASE_DUTY  = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DIV_INIT,
      ST_DIV,
      ST_ERR,
      ST_MUL_P,
      ST_MUL_D,
      ST_MUL_IL,
      ST_MUL_IH,
      ST_ACC_I,
      ST_ACC_T,
      ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROOT,
      OP_DIV_INIT,
      OP_DIV,
      OP_ERR,
      OP_MUL_P,
      OP_MUL_D,
      OP_MUL_IL,
      OP_MUL_IH,
      OP_ACC_I,
      OP_ACC_T,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

endpackage

// ===== design/lsps_chan_if.sv =====
// Handshake channels of the steering unit: sensor item in, duty item out.
interface lsps_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsps_pkg::IN_W-1:0]     sample_0;
   logic [lsps_pkg::IN_W-1:0]     sample_1;
   logic [lsps_pkg::IN_W-1:0]     sample_2;
   logic [lsps_pkg::IN_W-1:0]     sample_3;
   logic [lsps_pkg::IN_W-1:0]     sample_4;
   logic [lsps_pkg::IN_W-1:0]     sample_5;
   logic [lsps_pkg::IN_W-1:0]     sample_6;
   logic [lsps_pkg::IN_W-1:0]     sample_7;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, input ready);
   modport sink   (input valid, sample_0, sample_1, sample_2, sample_3,
                   sample_4, sample_5, sample_6, sample_7, output ready);
endinterface

interface lsps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [lsps_pkg::DUTY_W-1:0] left_duty;
   logic signed [lsps_pkg::DUTY_W-1:0] right_duty;
   logic                               clipped;

   modport source (output valid, left_duty, right_duty, clipped, input ready);
   modport sink   (input valid, left_duty, right_duty, clipped, output ready);
endinterface

// ===== design/lsps_ctrl.sv =====
// Sequencer of the steering unit: walks the datapath through one item.
module lsps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output lsps_pkg::cmd_type cmd
);
   import lsps_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      out_load  = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               cnt_in   = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.op = OP_ROOT;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(RT_STEPS - 1)) begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_DIV_INIT: begin
            cmd.op   = OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.op = OP_DIV;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.op   = OP_MUL_P;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            cmd.op   = OP_MUL_D;
            state_in = ST_MUL_IL;
         end
         ST_MUL_IL: begin
            cmd.op   = OP_MUL_IL;
            state_in = ST_MUL_IH;
         end
         ST_MUL_IH: begin
            cmd.op   = OP_MUL_IH;
            state_in = ST_ACC_I;
         end
         ST_ACC_I: begin
            cmd.op   = OP_ACC_I;
            state_in = ST_ACC_T;
         end
         ST_ACC_T: begin
            cmd.op   = OP_ACC_T;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = OP_OUT;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/lsps_dp.sv =====
// Datapath of the steering unit: sums, roots, divider, PID terms and outputs.
module lsps_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  lsps_pkg::cmd_type                     cmd,
   input  logic [lsps_pkg::IN_W-1:0]             sample_0,
   input  logic [lsps_pkg::IN_W-1:0]             sample_1,
   input  logic [lsps_pkg::IN_W-1:0]             sample_2,
   input  logic [lsps_pkg::IN_W-1:0]             sample_3,
   input  logic [lsps_pkg::IN_W-1:0]             sample_4,
   input  logic [lsps_pkg::IN_W-1:0]             sample_5,
   input  logic [lsps_pkg::IN_W-1:0]             sample_6,
   input  logic [lsps_pkg::IN_W-1:0]             sample_7,
   input  logic                                  csr_wr_en,
   input  logic [lsps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic signed [lsps_pkg::DUTY_W-1:0]    left_duty,
   output logic signed [lsps_pkg::DUTY_W-1:0]    right_duty,
   output logic                                  clipped
);
   import lsps_pkg::*;

   localparam logic signed [TERM_W-1:0] DUTY_MAX = TERM_W'(32767);
   localparam logic signed [TERM_W-1:0] DUTY_MIN = -TERM_W'(32768);
   localparam logic signed [ISUM_W:0]   ISUM_MAX = {2'b00, {(ISUM_W-1){1'b1}}};
   localparam logic signed [ISUM_W:0]   ISUM_MIN = {2'b11, {(ISUM_W-1){1'b0}}};

   // configuration registers
   logic [GAIN_W-1:0]       kp_ff, ki_ff, kd_ff;
   logic signed [OFS_W-1:0] target_ff;
   logic [BASE_W-1:0]       base_ff;

   // control state kept across items
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [ISUM_W-1:0] isum_ff;

   // per-item working registers
   logic [SUM_W-1:0]          a_ff, b_ff;
   logic [RX_W-1:0]           xa_ff, ra_ff, xb_ff, rb_ff, bit_ff;
   logic [DEN_W-1:0]          den_ff, rem_ff;
   logic [MAG_W-1:0]          quo_ff;
   logic                      neg_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic                      iclip_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [IACC_W-1:0]  iacc_ff;
   logic signed [TERM_W-1:0]  term_ff;
   logic signed [DUTY_W-1:0]  left_ff, right_ff;
   logic                      clip_ff;

   logic [SUM_W-1:0]          a_sum, b_sum;
   logic [RX_W-1:0]           xa_in, ra_in, xb_in, rb_in;
   logic signed [RT_W:0]      rdiff;
   logic [RT_W-1:0]           rmag;
   logic [DEN_W:0]            trial;
   logic                      take;
   logic signed [ERR_W-1:0]   bias, err;
   logic signed [ISUM_W:0]    isum_raw;
   logic signed [ISUM_W-1:0]  isum_sat;
   logic                      isum_clip;
   logic signed [GAIN_W:0]    mul_a;
   logic signed [MOP_W-1:0]   mul_b;
   logic signed [TERM_W-1:0]  rnd, pid, left_raw, right_raw;

   function automatic logic [SUM_W-1:0] ext_s(input logic [IN_W-1:0] s);
      return SUM_W'(s[SAMPLE_BITS-1:0]);
   endfunction

   assign a_sum = ext_s(sample_0) + ext_s(sample_1) + ext_s(sample_2) + ext_s(sample_3);
   assign b_sum = ext_s(sample_4) + ext_s(sample_5) + ext_s(sample_6) + ext_s(sample_7);

   // one root digit per lane per cycle
   always_comb begin
      xa_in = xa_ff;
      ra_in = ra_ff >> 1;
      if (xa_ff >= ra_ff + bit_ff) begin
         xa_in = xa_ff - (ra_ff + bit_ff);
         ra_in = (ra_ff >> 1) + bit_ff;
      end
      xb_in = xb_ff;
      rb_in = rb_ff >> 1;
      if (xb_ff >= rb_ff + bit_ff) begin
         xb_in = xb_ff - (rb_ff + bit_ff);
         rb_in = (rb_ff >> 1) + bit_ff;
      end
   end

   assign rdiff = signed'({1'b0, ra_ff[RT_W-1:0]}) - signed'({1'b0, rb_ff[RT_W-1:0]});
   assign rmag  = rdiff[RT_W] ? RT_W'(-rdiff) : rdiff[RT_W-1:0];

   // restoring divide, one quotient bit per cycle
   assign trial = {rem_ff, quo_ff[MAG_W-1]};
   assign take  = (trial >= {1'b0, den_ff});

   always_comb begin
      if (den_ff == '0) begin
         bias = '0;
      end else if (neg_ff) begin
         bias = -signed'(ERR_W'(quo_ff[ERR_W-2:0]));
      end else begin
         bias = signed'(ERR_W'(quo_ff[ERR_W-2:0]));
      end
      err      = ERR_W'(target_ff) - bias;
      isum_raw = (ISUM_W+1)'(isum_ff) + (ISUM_W+1)'(err);
      isum_clip = 1'b0;
      if (isum_raw > ISUM_MAX) begin
         isum_sat  = ISUM_MAX[ISUM_W-1:0];
         isum_clip = 1'b1;
      end else if (isum_raw < ISUM_MIN) begin
         isum_sat  = ISUM_MIN[ISUM_W-1:0];
         isum_clip = 1'b1;
      end else begin
         isum_sat = isum_raw[ISUM_W-1:0];
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = signed'({1'b0, kp_ff});
      mul_b = MOP_W'(err_ff);
      priority case (cmd.op)
         OP_MUL_D: begin
            mul_a = signed'({1'b0, kd_ff});
            mul_b = MOP_W'(diff_ff);
         end
         OP_MUL_IL: begin
            mul_a = signed'({1'b0, ki_ff});
            mul_b = signed'(MOP_W'(isum_ff[ISUM_LO_W-1:0]));
         end
         OP_MUL_IH: begin
            mul_a = signed'({1'b0, ki_ff});
            mul_b = MOP_W'(signed'(isum_ff[ISUM_W-1:ISUM_LO_W]));
         end
         default: ;
      endcase
   end

   assign rnd       = term_ff + TERM_W'(16384);
   assign pid       = rnd >>> 15;
   assign left_raw  = signed'(TERM_W'(base_ff)) + pid;
   assign right_raw = signed'(TERM_W'(base_ff)) - pid;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff       <= GAIN_W'(7062356);
         ki_ff       <= GAIN_W'(655360);
         kd_ff       <= GAIN_W'(1304166);
         target_ff   <= OFS_W'(88858);
         base_ff     <= BASE_W'(4588);
         last_err_ff <= '0;
         isum_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_idx_type'(csr_index))
               CSR_PROP_GAIN:  kp_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_INTEG_GAIN: ki_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN: kd_ff     <= csr_wdata[GAIN_W-1:0];
               CSR_TARGET_OFS: target_ff <= csr_wdata[OFS_W-1:0];
               CSR_BASE_DUTY:  base_ff   <= csr_wdata[BASE_W-1:0];
               default: ;
            endcase
         end
         if (cmd.op == OP_ERR) begin
            last_err_ff <= err;
            isum_ff     <= isum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            a_ff   <= a_sum;
            b_ff   <= b_sum;
            xa_ff  <= RX_W'({a_sum, 32'b0});
            xb_ff  <= RX_W'({b_sum, 32'b0});
            ra_ff  <= '0;
            rb_ff  <= '0;
            bit_ff <= RX_W'(1) << (RX_W - 2);
         end
         OP_ROOT: begin
            xa_ff  <= xa_in;
            ra_ff  <= ra_in;
            xb_ff  <= xb_in;
            rb_ff  <= rb_in;
            bit_ff <= bit_ff >> 2;
         end
         OP_DIV_INIT: begin
            neg_ff <= rdiff[RT_W];
            quo_ff <= {rmag, 14'b0};
            rem_ff <= '0;
            den_ff <= DEN_W'(a_ff) + DEN_W'(b_ff);
         end
         OP_DIV: begin
            rem_ff <= take ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[MAG_W-2:0], take};
         end
         OP_ERR: begin
            err_ff   <= err;
            diff_ff  <= DIFF_W'(err) - DIFF_W'(last_err_ff);
            iclip_ff <= isum_clip;
         end
         OP_MUL_P: begin
            prod_ff <= mul_a * mul_b;
            term_ff <= '0;
         end
         OP_MUL_D, OP_MUL_IL: begin
            prod_ff <= mul_a * mul_b;
            term_ff <= term_ff + TERM_W'(prod_ff >>> 16);
         end
         OP_MUL_IH: begin
            prod_ff <= mul_a * mul_b;
            iacc_ff <= IACC_W'(prod_ff);
         end
         OP_ACC_I: iacc_ff <= iacc_ff + (IACC_W'(prod_ff) <<< ISUM_LO_W);
         OP_ACC_T: term_ff <= term_ff + TERM_W'(iacc_ff >>> 16);
         OP_OUT: begin
            clip_ff <= iclip_ff || (left_raw > DUTY_MAX) || (left_raw < DUTY_MIN)
                       || (right_raw > DUTY_MAX) || (right_raw < DUTY_MIN);
            if (left_raw > DUTY_MAX)       left_ff <= DUTY_MAX[DUTY_W-1:0];
            else if (left_raw < DUTY_MIN)  left_ff <= DUTY_MIN[DUTY_W-1:0];
            else                           left_ff <= left_raw[DUTY_W-1:0];
            if (right_raw > DUTY_MAX)      right_ff <= DUTY_MAX[DUTY_W-1:0];
            else if (right_raw < DUTY_MIN) right_ff <= DUTY_MIN[DUTY_W-1:0];
            else                           right_ff <= right_raw[DUTY_W-1:0];
         end
         default: ;
      endcase
   end

   assign left_duty  = left_ff;
   assign right_duty = right_ff;
   assign clipped    = clip_ff;

endmodule

// ===== design/line_sensor_pid_steering_unit.sv =====
// Top level of the line-sensor PID steering unit.
// Usage:
//  - req_chan takes one item of eight sensor samples (low SAMPLE_BITS bits used).
//    Left sum is samples 0..3, right sum samples 4..7.
//  - rsp_chan gives one item per request: left/right duty in signed Q1.15 and
//    a clipped flag (duty or integral saturated).
//  - csr_* is a plain write port: gains, target offset, base duty. Write it
//    only while no item is in flight.
// Sequence: from acceptance to the result register an item passes through the
//  23 two-bit root steps (both sums in parallel), the divider setup and the 37
//  one-bit restoring divide steps, then the error step and one shared
//  multiplier used in the MUL_P, MUL_D, MUL_IL and MUL_IH states. One item is
//  worked on at a time; req ready is high only while the sequencer is idle.
// Stall: the result sits in an output register; a new item is accepted while
//  it waits, and the next result is held back until the old one is taken.
// Reset (synchronous, active high): registers return to their default
//  settings, the integral and last error clear, no result is pending.
module line_sensor_pid_steering_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   lsps_req_if.sink                              req_chan,
   lsps_rsp_if.source                            rsp_chan,
   input  logic                                  csr_wr_en,
   input  logic [lsps_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [lsps_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import lsps_pkg::*;

   cmd_type cmd;
   logic    req_ready;
   logic    rsp_valid;

   lsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   lsps_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_0   (req_chan.sample_0),
      .sample_1   (req_chan.sample_1),
      .sample_2   (req_chan.sample_2),
      .sample_3   (req_chan.sample_3),
      .sample_4   (req_chan.sample_4),
      .sample_5   (req_chan.sample_5),
      .sample_6   (req_chan.sample_6),
      .sample_7   (req_chan.sample_7),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .left_duty  (rsp_chan.left_duty),
      .right_duty (rsp_chan.right_duty),
      .clipped    (rsp_chan.clipped)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

// ===== bench/line_sensor_pid_steering_unit_tb.sv =====
// Testbench for the line-sensor PID steering unit: random and directed items, checked by a predictor.
module line_sensor_pid_steering_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsps_pkg::*;

   typedef logic [7:0][IN_W-1:0] frame_type;

   typedef struct {
      logic signed [DUTY_W-1:0] left_duty;
      logic signed [DUTY_W-1:0] right_duty;
      logic                     clipped;
   } duty_type;

   localparam longint ISUM_MAX = 64'sd549755813887;
   localparam longint ISUM_MIN = -ISUM_MAX - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lsps_req_if req_chan ();
   lsps_rsp_if rsp_chan ();

   line_sensor_pid_steering_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and loop state
   logic [GAIN_W-1:0] kp, ki, kd;
   longint            tgt_ofs;
   logic [BASE_W-1:0] base;
   longint            prev_err, integ;

   frame_type frames_pending[$];
   duty_type  duty_expected[$];
   bit        req_took = 1'b0;
   bit        calm = 1'b0;       // no idling on either side while set
   int        mismatches = 0;

   // floor(sqrt(s * 2^32)) by bit pairs
   function automatic longint unsigned root_q16(input longint unsigned s);
      longint unsigned x, r, b;
      x = s << 32;
      r = 0;
      b = 64'd1 << 50;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // one control step: updates the loop state and gives the duty item
   function automatic duty_type steer_step(input frame_type f);
      longint unsigned a, b, mag, q;
      longint d, bias, err, diff, acc, pid, lft, rgt;
      duty_type o;
      a = 0;
      b = 0;
      bias = 0;
      o.clipped = 1'b0;
      for (int i = 0; i < 4; i++) a += f[i][SAMPLE_BITS-1:0];
      for (int i = 4; i < 8; i++) b += f[i][SAMPLE_BITS-1:0];
      if (a + b != 0) begin
         d = longint'(root_q16(a)) - longint'(root_q16(b));
         mag = (d < 0 ? -d : d) << 14;
         q = mag / (a + b);
         bias = d < 0 ? -longint'(q) : longint'(q);
      end
      err = tgt_ofs - bias;
      diff = err - prev_err;
      acc = integ + err;
      if (acc > ISUM_MAX) begin
         acc = ISUM_MAX;
         o.clipped = 1'b1;
      end
      if (acc < ISUM_MIN) begin
         acc = ISUM_MIN;
         o.clipped = 1'b1;
      end
      integ = acc;
      prev_err = err;
      pid = ((longint'(kp) * err) >>> 16) + ((longint'(ki) * acc) >>> 16)
          + ((longint'(kd) * diff) >>> 16);
      pid = (pid + 16384) >>> 15;
      lft = longint'(base) + pid;
      rgt = longint'(base) - pid;
      if (lft > 32767) begin lft = 32767; o.clipped = 1'b1; end
      if (lft < -32768) begin lft = -32768; o.clipped = 1'b1; end
      if (rgt > 32767) begin rgt = 32767; o.clipped = 1'b1; end
      if (rgt < -32768) begin rgt = -32768; o.clipped = 1'b1; end
      o.left_duty = lft[DUTY_W-1:0];
      o.right_duty = rgt[DUTY_W-1:0];
      return o;
   endfunction

   // random frame: full range, near dark, one side dark, or each sample all ones or zero
   function automatic frame_type rand_frame();
      frame_type f;
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
         if (mode < 5) f[i] = IN_W'($urandom);
         else if (mode < 7) f[i] = IN_W'($urandom_range(0, 3));
         else if (mode < 8) f[i] = (i < 4) ? IN_W'($urandom) : '0;
         else if (mode < 9) f[i] = (i < 4) ? '0 : IN_W'($urandom);
         else f[i] = $urandom_range(0, 1) ? {IN_W{1'b1}} : '0;
      end
      return f;
   endfunction

   // register write at the falling edge; predictor follows it
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_PROP_GAIN:  kp = v[GAIN_W-1:0];
         CSR_INTEG_GAIN: ki = v[GAIN_W-1:0];
         CSR_DERIV_GAIN: kd = v[GAIN_W-1:0];
         CSR_TARGET_OFS: tgt_ofs = longint'($signed(v[OFS_W-1:0]));
         CSR_BASE_DUTY:  base = v[BASE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // wait for the block to go idle: everything sent and answered, then latency
   task automatic drain();
      while (frames_pending.size() != 0 || req_chan.valid || duty_expected.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // driver: new item or idle at the falling edge
   initial begin
      req_chan.valid = 1'b0;
      req_chan.sample_0 = '0; req_chan.sample_1 = '0; req_chan.sample_2 = '0;
      req_chan.sample_3 = '0; req_chan.sample_4 = '0; req_chan.sample_5 = '0;
      req_chan.sample_6 = '0; req_chan.sample_7 = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      frame_type f;
      if (!reset) begin
         if (!req_chan.valid || req_took) begin
            if (frames_pending.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
               f = frames_pending.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.sample_0 <= f[0]; req_chan.sample_1 <= f[1];
               req_chan.sample_2 <= f[2]; req_chan.sample_3 <= f[3];
               req_chan.sample_4 <= f[4]; req_chan.sample_5 <= f[5];
               req_chan.sample_6 <= f[6]; req_chan.sample_7 <= f[7];
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         req_took <= 1'b0;
         rsp_chan.ready <= calm || $urandom_range(0, 99) >= 13;
      end
   end

   // monitor: predict on acceptance, compare each result with the oldest expectation
   always @(posedge clock) begin
      frame_type f;
      duty_type  want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            f = {req_chan.sample_7, req_chan.sample_6, req_chan.sample_5, req_chan.sample_4,
                 req_chan.sample_3, req_chan.sample_2, req_chan.sample_1, req_chan.sample_0};
            duty_expected.push_back(steer_step(f));
            req_took <= 1'b1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (duty_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected item: left %0d right %0d clipped %0b",
                           rsp_chan.left_duty, rsp_chan.right_duty, rsp_chan.clipped);
            end else begin
               want = duty_expected.pop_front();
               if (rsp_chan.left_duty !== want.left_duty || rsp_chan.right_duty !== want.right_duty
                   || rsp_chan.clipped !== want.clipped) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: left %0d/%0d right %0d/%0d clipped %0b/%0b (exp/act)",
                              want.left_duty, rsp_chan.left_duty, want.right_duty,
                              rsp_chan.right_duty, want.clipped, rsp_chan.clipped);
               end
            end
         end
      end
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   // stimulus phases
   initial begin
      frame_type f;
      kp = 24'd7062356; ki = 24'd655360; kd = 24'd1304166;
      tgt_ofs = 88858; base = 15'd4588;
      prev_err = 0; integ = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: dark, full, one side lit, single counts, alternating bit patterns, then random
      frames_pending.push_back('0);
      frames_pending.push_back({8{{IN_W{1'b1}}}});
      frames_pending.push_back({{4{IN_W'(0)}}, {4{{IN_W{1'b1}}}}});
      frames_pending.push_back({{4{{IN_W{1'b1}}}}, {4{IN_W'(0)}}});
      frames_pending.push_back({{7{IN_W'(0)}}, IN_W'(1)});
      frames_pending.push_back({IN_W'(1), {7{IN_W'(0)}}});
      frames_pending.push_back({8{IN_W'('hAAA)}});
      frames_pending.push_back({8{IN_W'('h555)}});
      frames_pending.push_back({{4{IN_W'('h555)}}, {4{IN_W'('hAAA)}}});
      frames_pending.push_back({{4{IN_W'(1)}}, {4{IN_W'(2)}}});
      for (int i = 0; i < 6; i++) frames_pending.push_back(rand_frame());
      drain();

      // random settings, including writes to unused indexes
      for (int r = 0; r < 8; r++) write_csr(CSR_IDX_W'(r), CSR_DATA_W'($urandom));
      for (int i = 0; i < 150; i++) frames_pending.push_back(rand_frame());
      drain();

      // upper extremes, no idling on either side
      calm = 1'b1;
      write_csr(CSR_PROP_GAIN, {CSR_DATA_W{1'b1}});
      write_csr(CSR_INTEG_GAIN, {CSR_DATA_W{1'b1}});
      write_csr(CSR_DERIV_GAIN, {CSR_DATA_W{1'b1}});
      write_csr(CSR_TARGET_OFS, 31'h3FFF_FFFF);
      write_csr(CSR_BASE_DUTY, 31'h7FFF);
      for (int i = 0; i < 100; i++) frames_pending.push_back(rand_frame());
      drain();
      calm = 1'b0;

      // lower extremes
      write_csr(CSR_PROP_GAIN, '0);
      write_csr(CSR_INTEG_GAIN, '0);
      write_csr(CSR_DERIV_GAIN, '0);
      write_csr(CSR_TARGET_OFS, 31'h4000_0000);
      write_csr(CSR_BASE_DUTY, '0);
      for (int i = 0; i < 50; i++) frames_pending.push_back(rand_frame());
      drain();

      // drive the integral into its lower limit with the largest negative error
      write_csr(CSR_INTEG_GAIN, CSR_DATA_W'($urandom_range(1, 65536)));
      write_csr(CSR_BASE_DUTY, CSR_DATA_W'($urandom));
      for (int i = 0; i < 300; i++) begin
         f = '0;
         f[3'($urandom_range(0, 3))] = IN_W'(1);
         if ($urandom_range(0, 9) == 0) f = rand_frame();
         frames_pending.push_back(f);
      end
      drain();

      // random settings and items to unwind the integral
      write_csr(CSR_PROP_GAIN, CSR_DATA_W'($urandom));
      write_csr(CSR_DERIV_GAIN, CSR_DATA_W'($urandom));
      write_csr(CSR_TARGET_OFS, 31'h3FFF_FFFF);
      for (int i = 0; i < 200; i++) frames_pending.push_back(rand_frame());
      drain();

      if (mismatches == 0 && duty_expected.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
